### rtl/core/iafp_pkg.sv
// ----------------------------------------------------------------------------
// iafp_pkg
// Shared widths, frame constants and the frame handoff type of the IMU
// acceleration frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iafp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned NumSmp   = 2 * NumAxes;
  localparam int unsigned RawW     = 16;
  localparam int unsigned ScaleW   = 13;
  localparam int unsigned ProdW    = RawW + ScaleW;
  localparam int unsigned FracW    = 12;
  localparam int unsigned AccelW   = ProdW - FracW;
  localparam int unsigned OutDataW = 56;

  localparam logic [CountW-1:0] PosSync   = 4'd0;
  localparam logic [CountW-1:0] PosKind   = 4'd1;
  localparam logic [CountW-1:0] PosSmpLo  = 4'd2;
  localparam logic [CountW-1:0] PosSmpHi  = 4'd7;
  localparam logic [CountW-1:0] PosCsum   = 4'd10;

  localparam logic [ByteW-1:0]  SyncByte  = 8'h55;
  localparam logic [ByteW-1:0]  KindAccel = 8'h51;
  localparam logic [ScaleW-1:0] ScaleQ12  = 13'd5018;

  typedef struct packed {
    logic                         vld;
    logic [NumSmp-1:0][ByteW-1:0] smp;
  } frame_t;

endpackage

`default_nettype wire

### rtl/core/iafp_frame.sv
// ----------------------------------------------------------------------------
// iafp_frame
// Byte framer: counts bytes into 11-byte frames, checks sync, kind and
// checksum, and holds the six sample bytes of a good frame for scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iafp_frame (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       beat_i,
  input  wire logic [iafp_pkg::ByteW-1:0] byte_i,
  input  wire logic                       burst_end_i,
  input  wire logic                       take_i,
  output iafp_pkg::frame_t                frame_o
);
  import iafp_pkg::*;

  logic [CountW-1:0]            pos_q, pos_d;
  logic [ByteW-1:0]             sum_q, sum_d;
  logic                         hdr_q, hdr_d;
  logic [NumSmp-1:0][ByteW-1:0] smp_q, smp_d;
  frame_t                       frm_q, frm_d;
  logic [CountW-1:0]            smp_off;

  assign smp_off = pos_q - PosSmpLo;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    hdr_d = hdr_q;
    smp_d = smp_q;
    frm_d = frm_q;
    if (take_i) begin
      frm_d.vld = 1'b0;
    end
    if (beat_i) begin
      if (pos_q == PosSync) begin
        hdr_d = (byte_i == SyncByte);
        sum_d = byte_i;
      end else if (pos_q == PosKind) begin
        hdr_d = hdr_q && (byte_i == KindAccel);
        sum_d = sum_q + byte_i;
      end else if (pos_q < PosCsum) begin
        if (pos_q <= PosSmpHi) begin
          smp_d[smp_off[2:0]] = byte_i;
        end
        sum_d = sum_q + byte_i;
      end

      if (pos_q >= PosCsum) begin
        if (hdr_q && (byte_i == sum_q)) begin
          frm_d.vld = 1'b1;
          frm_d.smp = smp_q;
        end
        pos_d = PosSync;
      end else if (burst_end_i) begin
        pos_d = PosSync;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosSync;
      sum_q <= '0;
      hdr_q <= 1'b0;
      frm_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      hdr_q <= hdr_d;
      frm_q <= frm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  assign frame_o = frm_q;

endmodule

`default_nettype wire

### rtl/core/iafp_scale.sv
// ----------------------------------------------------------------------------
// iafp_scale
// Result stage: scales the three raw axes by 5018/4096 with flooring and
// holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iafp_scale (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire iafp_pkg::frame_t              frame_i,
  output logic                               take_o,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [iafp_pkg::OutDataW-1:0]      m_axis_tdata
);
  import iafp_pkg::*;

  logic                                   vld_q;
  logic [NumAxes-1:0][AccelW-1:0]         acc_q, acc_d;
  logic                                   load;

  always_comb begin
    logic signed [RawW-1:0]  raw;
    logic signed [ProdW-1:0] prod;
    for (int a = 0; a < NumAxes; a++) begin
      raw       = signed'({frame_i.smp[2*a+1], frame_i.smp[2*a]});
      prod      = ProdW'(raw) * signed'({1'b0, ScaleQ12});
      acc_d[a]  = prod[ProdW-1:FracW];
    end
  end

  assign load   = !vld_q || m_axis_tready;
  assign take_o = frame_i.vld && load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= frame_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      acc_q <= acc_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {{(OutDataW - NumAxes*AccelW){1'b0}}, acc_q[2], acc_q[1], acc_q[0]};

endmodule

`default_nettype wire

### rtl/core/imu_accel_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_accel_frame_parser
// IMU acceleration frame parser: serial bytes in, scaled x/y/z out.
//
// Input channel (s_axis): one byte per beat in tdata[7:0]; tlast marks the
// byte after which the line goes idle, ending the burst. Bytes gather into
// 11-byte frames; a long burst restarts the frame every 11 bytes, a burst
// shorter than a frame is dropped. Frames with a bad sync, kind or checksum
// give no result.
// Output channel (m_axis): one beat per good frame with accel_x, accel_y and
// accel_z as signed 17-bit values in 1/256 m/s^2.
// A good frame is registered in the framer, then scaled into the output
// register once that is free. Throughput: one byte per cycle; s_axis_tready
// drops only while one result waits on the output and a second one is held
// behind it. A stalled output keeps its beat stable until taken.
// Reset (rst_ni low, asynchronous) clears the frame position, checksum,
// header flag and both valid flags; no partial frame survives reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_accel_frame_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  wire logic                          s_axis_tlast,  // burst_end
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [16:0] accel_x, [33:17] accel_y, [50:34] accel_z, [55:51] zero
  output logic [iafp_pkg::OutDataW-1:0]      m_axis_tdata
);
  import iafp_pkg::*;

  frame_t frame;
  logic   take;
  logic   beat;

  assign s_axis_tready = !frame.vld || take;
  assign beat          = s_axis_tvalid && s_axis_tready;

  iafp_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .byte_i      (s_axis_tdata[ByteW-1:0]),
    .burst_end_i (s_axis_tlast),
    .take_i      (take),
    .frame_o     (frame)
  );

  iafp_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .take_o        (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the IMU acceleration frame parser. Byte beats go in on the
// input stream, with tlast ending a burst. A frame predictor keeps its own
// frame position, checksum, header flag and sample bytes, and queues the
// scaled x/y/z of every good frame. Each output beat is checked field by
// field against the oldest queued acceleration. Directed frames cover the
// axis extremes, a long burst and a short burst. Random frames cover good,
// corrupted and truncated frames, noise, and output backpressure. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import iafp_pkg::*;

  localparam int unsigned FrameLen   = 11;
  localparam int unsigned HangCycles = 1000;
  localparam int unsigned DrainTail  = 8;
  localparam logic signed [31:0] AccelScale = 32'sd5018;

  typedef enum {TX_BACK_TO_BACK, TX_RANDOM} tx_mode_e;
  typedef enum {RX_OPEN, RX_RANDOM, RX_HEAVY} rx_mode_e;
  typedef enum {BAD_SYNC, BAD_KIND, BAD_SUM, TRUNCATED} frame_fault_e;

  typedef struct {
    logic [AccelW-1:0] x;
    logic [AccelW-1:0] y;
    logic [AccelW-1:0] z;
  } accel_t;

  typedef logic [FrameLen-1:0][ByteW-1:0] imu_frame_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [7:0] data_byte
  logic                s_axis_tlast  = 1'b0;  // burst_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [16:0] accel_x, [33:17] accel_y, [50:34] accel_z, [55:51] zero
  logic [OutDataW-1:0] m_axis_tdata;

  accel_t accel_q[$];

  logic [CountW-1:0] frame_pos;
  logic [ByteW-1:0]  frame_sum;
  logic              header_ok;
  logic [ByteW-1:0]  sample_buf[NumSmp];

  tx_mode_e tx_mode = TX_RANDOM;
  rx_mode_e rx_mode = RX_RANDOM;
  int       rx_hold = 0;
  int       rx_roll;
  int       mismatches = 0;
  int       idle_cycles = 0;

  imu_accel_frame_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [AccelW-1:0] scale_axis(logic [7:0] lo, logic [7:0] hi);
    logic signed [15:0] raw;
    logic signed [31:0] prod;
    raw  = {hi, lo};
    prod = raw * AccelScale;
    return prod[FracW +: AccelW];
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic burst_end);
    accel_t a;
    if (frame_pos == PosSync) begin
      header_ok = (b == SyncByte);
      frame_sum = b;
    end else if (frame_pos == PosKind) begin
      header_ok = header_ok && (b == KindAccel);
      frame_sum = frame_sum + b;
    end else if (frame_pos < PosCsum) begin
      if (frame_pos <= PosSmpHi) sample_buf[frame_pos - PosSmpLo] = b;
      frame_sum = frame_sum + b;
    end
    if (frame_pos >= PosCsum) begin
      if (header_ok && b == frame_sum) begin
        a.x = scale_axis(sample_buf[0], sample_buf[1]);
        a.y = scale_axis(sample_buf[2], sample_buf[3]);
        a.z = scale_axis(sample_buf[4], sample_buf[5]);
        accel_q.push_back(a);
      end
      frame_pos = '0;
    end else if (burst_end) begin
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  function automatic int pick_gap();
    int roll;
    if (tx_mode == TX_BACK_TO_BACK) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic burst_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= burst_end;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, burst_end);
  endtask

  function automatic imu_frame_t seal_frame(imu_frame_t f);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < FrameLen - 1; i++) sum += f[i];
    f[FrameLen-1] = sum;
    return f;
  endfunction

  function automatic imu_frame_t make_frame(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    imu_frame_t f;
    f[0] = SyncByte;
    f[1] = KindAccel;
    {f[3], f[2]} = x;
    {f[5], f[4]} = y;
    {f[7], f[6]} = z;
    f[8] = 8'($urandom);
    f[9] = 8'($urandom);
    return seal_frame(f);
  endfunction

  function automatic imu_frame_t random_frame();
    return make_frame(16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  task automatic send_frame(input imu_frame_t f, input int nbytes, input logic end_burst);
    for (int i = 0; i < nbytes; i++)
      send_byte(f[i], (i == nbytes - 1) && end_burst);
  endtask

  task automatic realign();
    if (frame_pos != PosSync) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (accel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_extremes();
    tx_mode = TX_BACK_TO_BACK;
    send_frame(make_frame(16'h7FFF, 16'h8000, 16'h0000), FrameLen, 1'b0);
    send_frame(make_frame(16'hFFFF, 16'h0001, 16'h8001), FrameLen, 1'b1);
    send_byte(SyncByte, 1'b0);
    send_byte(KindAccel, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_good_frames(input int count);
    tx_mode = TX_RANDOM;
    rx_mode = RX_RANDOM;
    realign();
    repeat (count) send_frame(random_frame(), FrameLen, $urandom_range(0, 2) != 0);
  endtask

  task automatic test_corrupt_frames(input int count);
    imu_frame_t   f;
    frame_fault_e fault;
    tx_mode = TX_RANDOM;
    realign();
    repeat (count) begin
      f = random_frame();
      fault = frame_fault_e'($urandom_range(0, 3));
      case (fault)
        BAD_SYNC: begin
          do f[0] = 8'($urandom); while (f[0] == SyncByte);
          f = seal_frame(f);
        end
        BAD_KIND: begin
          do f[1] = 8'($urandom); while (f[1] == KindAccel);
          f = seal_frame(f);
        end
        BAD_SUM: begin
          f[FrameLen-1] ^= 8'($urandom_range(1, 255));
        end
        default: ;
      endcase
      if (fault == TRUNCATED) send_frame(f, $urandom_range(1, FrameLen - 1), 1'b1);
      else send_frame(f, FrameLen, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_noise(input int count);
    tx_mode = TX_RANDOM;
    repeat (count) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_output_stall(input int count);
    tx_mode = TX_BACK_TO_BACK;
    rx_mode = RX_HEAVY;
    realign();
    repeat (count) send_frame(random_frame(), FrameLen, 1'b0);
    rx_mode = RX_RANDOM;
  endtask

  function automatic void check_field(string name, logic [AccelW-1:0] want, logic [AccelW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
    end
  endfunction

  function automatic void check_beat(logic [OutDataW-1:0] d);
    accel_t want;
    if (accel_q.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with none expected, actual %h", $time, d);
      return;
    end
    want = accel_q.pop_front();
    check_field("accel_x", want.x, d[0*AccelW +: AccelW]);
    check_field("accel_y", want.y, d[1*AccelW +: AccelW]);
    check_field("accel_z", want.z, d[2*AccelW +: AccelW]);
    check_field("pad", '0, AccelW'(d[OutDataW-1:3*AccelW]));
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_beat(m_axis_tdata);
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else if (rx_mode == RX_OPEN) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < ((rx_mode == RX_HEAVY) ? 30 : 75)) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (rx_roll >= 95 || (rx_mode == RX_HEAVY && rx_roll >= 70))
          rx_hold = $urandom_range(10, 40);
        else
          rx_hold = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else if (rst_ni)
      idle_cycles++;
    if (idle_cycles >= HangCycles) begin
      $display("%0t: no beat for %0d cycles", $time, HangCycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    frame_pos = '0;
    frame_sum = '0;
    header_ok = 1'b0;
    foreach (sample_buf[i]) sample_buf[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_good_frames(12);
    wait_for_results();
    test_corrupt_frames(10);
    test_noise(60);
    test_output_stall(6);
    wait_for_results();
    test_good_frames(6);
    test_noise(20);

    wait_for_results();
    repeat (DrainTail) @(posedge clk_i);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
rtl/core/iafp_pkg.sv
rtl/core/iafp_frame.sv
rtl/core/iafp_scale.sv
rtl/core/imu_accel_frame_parser.sv
test/tb_top.sv
